/* rtl/core/msrt_pkg.sv */
// shared types and constants for the multi-slot repeat timer
// no dependencies; used by the top level and by the port checker
package msrt_pkg;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int ELAPSED_W = 16;
  localparam int DELAY_W  = 24;
  localparam int REPEAT_W = 17;
  localparam int HANDLE_W = 16;
  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 4;
  localparam int REMAIN_W = 25;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ARM    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_FIRED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ARMED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK   = 3'd4;

  // repeat count that never runs out
  localparam logic signed [REPEAT_W-1:0] REPEAT_FOREVER = -17'sd1;

  // one slot as stored in the slot memory
  typedef struct packed {
    logic signed [REMAIN_W-1:0] remaining;
    logic [DELAY_W-1:0]         period;
    logic signed [REPEAT_W-1:0] repeats;
    logic [HANDLE_W-1:0]        handle;
  } slot_entry_t;

endpackage

/* rtl/core/multi_slot_repeat_timer.sv */
// Multi-slot repeat timer: a table of SLOT_COUNT timer slots whose time, period, repeat count
// and handle live in one slot memory with a registered read; active flags are flip-flops
// that reset clears. For an arm item the lowest free slot is found from the active flags and
// written at once, and the armed or table-full result follows. A tick or a cancel item walks
// the slot memory one slot per cycle while no firing slot waits on the output register (read
// of the next slot overlapping the write-back of the current one), then gives its closing
// result. Only one item is in work at a time; the next is taken once the closing result
// sits in the output register. Depends on msrt_pkg.
module multi_slot_repeat_timer #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [msrt_pkg::FUNC_W-1:0]            func,
  input  logic [msrt_pkg::ELAPSED_W-1:0]         elapsed_ms,
  input  logic [msrt_pkg::DELAY_W-1:0]           arm_delay,
  input  logic signed [msrt_pkg::REPEAT_W-1:0]   repeat_count,
  input  logic [msrt_pkg::HANDLE_W-1:0]          handle,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [msrt_pkg::KIND_W-1:0]            kind,
  output logic [msrt_pkg::INDEX_W-1:0]           slot_index,
  output logic [msrt_pkg::HANDLE_W-1:0]          fired_handle,
  output logic                                   last
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_TICK   = 2'd1;
  localparam logic [1:0] S_CANCEL = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]                          state;
  logic [1:0]                          state_next;
  logic [SW-1:0]                       cur;
  logic [SLOT_COUNT-1:0]               active;
  logic [msrt_pkg::ELAPSED_W-1:0]      elapsed_q;
  logic [msrt_pkg::HANDLE_W-1:0]       handle_q;
  logic [msrt_pkg::KIND_W-1:0]         done_kind;

  // slot memory
  msrt_pkg::slot_entry_t               slot_mem [SLOT_COUNT];
  msrt_pkg::slot_entry_t               rd_data;
  msrt_pkg::slot_entry_t               wr_data;
  msrt_pkg::slot_entry_t               walk_data;
  logic                                rd_en;
  logic [SW-1:0]                       rd_addr;
  logic                                wr_en;
  logic [SW-1:0]                       wr_addr;

  logic                                out_free;
  logic                                accept;
  logic                                arm_go;
  logic                                walk_go;
  logic                                free_found;
  logic [SW-1:0]                       free_idx;
  logic                                walking;
  logic                                fire;
  logic                                clear;
  logic                                touch;
  logic                                adv;
  logic signed [msrt_pkg::REMAIN_W-1:0] rem_sub;
  logic signed [msrt_pkg::REMAIN_W-1:0] reload;

  // handshake
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;
  assign arm_go   = accept && (func == msrt_pkg::FUNC_ARM);
  assign walk_go  = accept && ((func == msrt_pkg::FUNC_TICK) ||
                               (func == msrt_pkg::FUNC_CANCEL));
  assign walking  = (state == S_TICK) || (state == S_CANCEL);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  // per-slot update for tick and cancel
  assign rem_sub = rd_data.remaining - $signed({9'd0, elapsed_q});
  assign reload  = $signed({1'b0, rd_data.period});

  always_comb begin
    fire      = 1'b0;
    clear     = 1'b0;
    touch     = 1'b0;
    walk_data = rd_data;
    if (state == S_TICK && active[cur]) begin
      touch = 1'b1;
      if (rd_data.remaining <= 0) begin
        fire  = 1'b1;
        clear = 1'b1;
      end else begin
        walk_data.remaining = rem_sub;
        if (rem_sub <= 0) begin
          fire = 1'b1;
          if (rd_data.repeats == msrt_pkg::REPEAT_FOREVER) begin
            walk_data.remaining = reload;
          end else if (!rd_data.repeats[msrt_pkg::REPEAT_W-1] && rd_data.repeats != 0) begin
            walk_data.repeats   = rd_data.repeats - 17'sd1;
            walk_data.remaining = reload;
          end else begin
            clear = 1'b1;
          end
        end
      end
    end else if (state == S_CANCEL && active[cur] && rd_data.handle == handle_q) begin
      clear = 1'b1;
    end
  end

  // a firing slot waits until the output register is free
  assign adv = walking && !(fire && !out_free);

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (walk_go) begin
      rd_en = 1'b1;
    end else if (adv && cur != LAST_SLOT) begin
      rd_en   = 1'b1;
      rd_addr = SW'({1'b0, cur} + 1'b1);
    end
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = walk_data;
    if (arm_go && free_found) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data.remaining = $signed({1'b0, arm_delay});
      wr_data.period    = arm_delay;
      wr_data.repeats   = repeat_count;
      wr_data.handle    = handle;
    end else if (adv && touch) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= slot_mem[rd_addr];
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (walk_go) begin
          state_next = (func == msrt_pkg::FUNC_TICK) ? S_TICK : S_CANCEL;
        end
      end
      S_TICK, S_CANCEL: begin
        if (adv && cur == LAST_SLOT) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cur    <= '0;
      active <= '0;
    end else begin
      state <= state_next;
      if (walk_go) begin
        cur <= '0;
      end else if (adv && cur != LAST_SLOT) begin
        cur <= SW'({1'b0, cur} + 1'b1);
      end
      if (arm_go && free_found) begin
        active[free_idx] <= 1'b1;
      end else if (adv && clear) begin
        active[cur] <= 1'b0;
      end
    end
  end

  // latched request fields
  always_ff @(posedge clk) begin
    if (walk_go) begin
      elapsed_q <= elapsed_ms;
      handle_q  <= handle;
      done_kind <= (func == msrt_pkg::FUNC_TICK) ? msrt_pkg::KIND_TICK : msrt_pkg::KIND_CANCEL;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (arm_go || (adv && fire) || (state == S_DONE && out_free)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (arm_go) begin
      kind         <= free_found ? msrt_pkg::KIND_ARMED : msrt_pkg::KIND_FULL;
      slot_index   <= free_found ? msrt_pkg::INDEX_W'(free_idx) : '0;
      fired_handle <= free_found ? handle : '0;
      last         <= 1'b1;
    end else if (adv && fire) begin
      kind         <= msrt_pkg::KIND_FIRED;
      slot_index   <= msrt_pkg::INDEX_W'(cur);
      fired_handle <= rd_data.handle;
      last         <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      kind         <= done_kind;
      slot_index   <= '0;
      fired_handle <= '0;
      last         <= 1'b1;
    end
  end

endmodule

/* rtl/core/msrt_checker.sv */
// port-level checks for multi_slot_repeat_timer, bound to the top level
// depends on msrt_pkg
module msrt_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [msrt_pkg::FUNC_W-1:0]       func,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [msrt_pkg::KIND_W-1:0]       kind,
  input logic [msrt_pkg::INDEX_W-1:0]      slot_index,
  input logic [msrt_pkg::HANDLE_W-1:0]     fired_handle,
  input logic                              last
);

  // a fired item never closes a request
  a_fired_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == msrt_pkg::KIND_FIRED |-> !last)
    else $error("fired item marked last");

  // status items carry no slot and no handle
  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == msrt_pkg::KIND_FULL || kind == msrt_pkg::KIND_CANCEL ||
                  kind == msrt_pkg::KIND_TICK)
    |-> slot_index == '0 && fired_handle == '0 && last)
    else $error("status item with slot or handle");

  // an accepted arm answers in the next cycle
  a_arm_answer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && func == msrt_pkg::FUNC_ARM
    |=> out_valid && (kind == msrt_pkg::KIND_ARMED || kind == msrt_pkg::KIND_FULL))
    else $error("arm without answer");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(slot_index) &&
                                $stable(fired_handle) && $stable(last))
    else $error("stalled result changed");

endmodule

bind multi_slot_repeat_timer msrt_checker u_msrt_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .func         (func),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .slot_index   (slot_index),
  .fired_handle (fired_handle),
  .last         (last)
);
